/* hdl/tsq_pkg.sv */
// Shared types, codes and helpers for the tone sequencer.
`timescale 1ns / 1ps
package tsq_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NOTE_DEPTH  = 3 * TABLE_DEPTH;
  localparam int NOTE_AW     = $clog2(NOTE_DEPTH);
  localparam logic [8:0] TD_LEN = 9'(TABLE_DEPTH);

  // command codes on the input channel
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_PAUSE  = 3'd2;
  localparam logic [2:0] CMD_RESUME = 3'd3;
  localparam logic [2:0] CMD_CLAIM  = 3'd4;
  localparam logic [2:0] CMD_LOAD   = 3'd5;

  localparam logic [1:0] CH_MELODY  = 2'd0;
  localparam logic [1:0] CH_HARMONY = 2'd1;
  localparam logic [1:0] CH_BASS    = 2'd2;
  localparam logic [1:0] CH_DRUM    = 2'd3;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_SILENCE = 2'd1;
  localparam logic [1:0] ACT_DRUM    = 2'd2;

  localparam logic [2:0] REG_CH1_LEN  = 3'd0;
  localparam logic [2:0] REG_CH1_LOOP = 3'd1;
  localparam logic [2:0] REG_CH2_LEN  = 3'd2;
  localparam logic [2:0] REG_CH3_LEN  = 3'd3;
  localparam logic [2:0] REG_DRUM_LEN = 3'd4;
  localparam logic [2:0] REG_REST     = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  chan;
    logic [7:0]  frames;
    logic [7:0]  eidx;
    logic [7:0]  dur;
    logic [15:0] pitch;
    logic [7:0]  env;
    logic [7:0]  noise;
  } qitem_t;

  typedef struct packed {
    logic [1:0]  chan;
    logic [1:0]  action;
    logic [10:0] pitch;
    logic [7:0]  env;
    logic [7:0]  noise;
  } result_t;

  typedef struct packed {
    logic busy;
    logic hold_v;
  } eng_stat_t;

  // table length clipped to the table depth
  function automatic logic [8:0] eff_len(input logic [7:0] len);
    logic [8:0] l9;
    l9 = {1'b0, len};
    return (l9 > TD_LEN) ? TD_LEN : l9;
  endfunction

  // flat address of a pitched-channel entry
  function automatic logic [NOTE_AW-1:0] note_addr(input logic [1:0] ch,
                                                   input logic [7:0] idx);
    return NOTE_AW'(ch) * NOTE_AW'(TABLE_DEPTH) + NOTE_AW'(idx[TBL_AW-1:0]);
  endfunction

endpackage

/* hdl/tsq_front.sv */
// Front end: takes input transactions, drops no-op commands, queues the rest.
`timescale 1ns / 1ps
module tsq_front import tsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [4:0]  in_tuser,
  output logic        q_valid,
  output qitem_t      q_item,
  input  logic        q_pop
);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  qitem_t            fifo_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  qitem_t            item;
  logic              keep;
  logic              push;

  always_comb begin
    item.op     = in_tuser[2:0];
    item.chan   = in_tuser[4:3];
    item.frames = in_tdata[7:0];
    item.eidx   = in_tdata[15:8];
    item.dur    = in_tdata[23:16];
    item.pitch  = in_tdata[39:24];
    item.env    = in_tdata[47:40];
    item.noise  = in_tdata[55:48];
  end

  // commands that change nothing never reach the back end
  always_comb begin
    unique case (item.op)
      CMD_TICK, CMD_START, CMD_PAUSE, CMD_RESUME: keep = 1'b1;
      CMD_CLAIM: keep = (item.chan != CH_BASS);
      CMD_LOAD:  keep = ({1'b0, item.eidx} < TD_LEN);
      default:   keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != Q_CW'(Q_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = Q_CW'(cnt_r + Q_CW'(push) - Q_CW'(q_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

endmodule

/* hdl/tsq_engine.sv */
// Back end: channel state, event tables, tick sequencer and result register.
`timescale 1ns / 1ps
module tsq_engine import tsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        q_valid,
  input  qitem_t      q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [3:0]  out_tuser,
  output logic        out_tlast,
  output eng_stat_t   stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADDR  = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_PSIL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  // configuration
  logic [7:0]  ch1_len_r, ch1_loop_r, ch2_len_r, ch3_len_r, drum_len_r;
  logic [15:0] rest_r;

  // channel state
  logic [2:0] state_r, state_nxt;
  logic [7:0] pos_r [3];
  logic [7:0] pos_nxt [3];
  logic [7:0] tmr_r [3];
  logic [7:0] tmr_nxt [3];
  logic [7:0] lst_r [3];
  logic [7:0] lst_nxt [3];
  logic [7:0] yld_r [3];
  logic [7:0] yld_nxt [3];
  logic [2:0] rtg_r, rtg_nxt;
  logic [7:0] dpos_r, dpos_nxt;
  logic [7:0] dtmr_r, dtmr_nxt;
  logic       play_r, play_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic       fire_r, fire_nxt;
  logic       emit_r, emit_nxt;

  // pending result and output register
  result_t hold_r, hold_nxt;
  logic    hold_v_r, hold_v_nxt;
  result_t out_r;
  logic    out_last_r;
  logic    out_v_r, out_v_nxt;
  logic    push;
  result_t push_res;
  logic    push_last;
  logic    out_free;
  logic    can_prod;

  // tables
  logic [23:0]        note_mem [NOTE_DEPTH];
  logic [23:0]        drum_mem [TABLE_DEPTH];
  logic [23:0]        note_rd_r, drum_rd_r;
  logic               note_we, drum_we, note_re, drum_re;
  logic [NOTE_AW-1:0] note_wa, note_ra;
  logic [TBL_AW-1:0]  drum_wa, drum_ra;

  // per-channel decision terms
  logic [8:0]  len, dlen;
  logic [7:0]  loop_fix, pos_fix, tdec, pos_adv, dtdec, dpos_fix, dpos_adv;
  logic [8:0]  pos_inc, dpos_inc;
  logic        held;
  logic [7:0]  dur, tval;
  result_t     new_res;

  assign out_free = !out_v_r || out_tready;
  assign can_prod = !hold_v_r || out_free;

  always_comb begin
    unique case (ch_r)
      CH_MELODY:  len = eff_len(ch1_len_r);
      CH_HARMONY: len = eff_len(ch2_len_r);
      CH_BASS:    len = eff_len(ch3_len_r);
      default:    len = eff_len(drum_len_r);
    endcase
    dlen = eff_len(drum_len_r);

    if (ch_r == CH_MELODY && {1'b0, ch1_loop_r} < len) begin
      loop_fix = ch1_loop_r;
    end else begin
      loop_fix = 8'd0;
    end

    // pitched channel terms; only used while ch_r names a pitched channel
    pos_fix  = 8'd0;
    tdec     = 8'd0;
    held     = 1'b0;
    if (ch_r != CH_DRUM) begin
      pos_fix = ({1'b0, pos_r[ch_r]} >= len) ? loop_fix : pos_r[ch_r];
      tdec    = (tmr_r[ch_r] != 8'd0) ? 8'(tmr_r[ch_r] - 8'd1) : 8'd0;
      held    = (ch_r != CH_BASS) && (yld_r[ch_r] != 8'd0);
    end
    pos_inc = {1'b0, pos_fix} + 9'd1;
    pos_adv = (pos_inc >= len) ? loop_fix : pos_inc[7:0];

    dtdec    = (dtmr_r != 8'd0) ? 8'(dtmr_r - 8'd1) : 8'd0;
    dpos_fix = ({1'b0, dpos_r} >= dlen) ? 8'd0 : dpos_r;
    dpos_inc = {1'b0, dpos_fix} + 9'd1;
    dpos_adv = (dpos_inc >= dlen) ? 8'd0 : dpos_inc[7:0];

    dur  = (ch_r == CH_DRUM) ? drum_rd_r[23:16] : note_rd_r[23:16];
    tval = (dur != 8'd0) ? dur : 8'd1;
  end

  // result built from the table word read for the current channel, or a silence during pause
  always_comb begin
    new_res = '0;
    new_res.chan = ch_r;
    if (state_r == S_PSIL) begin
      new_res.action = ACT_SILENCE;
    end else if (ch_r == CH_DRUM) begin
      new_res.action = ACT_DRUM;
      new_res.env    = drum_rd_r[15:8];
      new_res.noise  = drum_rd_r[7:0];
    end else if (note_rd_r[15:0] == rest_r) begin
      new_res.action = ACT_SILENCE;
    end else begin
      new_res.action = ACT_START;
      new_res.pitch  = note_rd_r[10:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      tmr_nxt[i] = tmr_r[i];
      lst_nxt[i] = lst_r[i];
      yld_nxt[i] = yld_r[i];
    end
    rtg_nxt    = rtg_r;
    dpos_nxt   = dpos_r;
    dtmr_nxt   = dtmr_r;
    play_nxt   = play_r;
    ch_nxt     = ch_r;
    fire_nxt   = fire_r;
    emit_nxt   = emit_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    push       = 1'b0;
    push_res   = hold_r;
    push_last  = 1'b0;
    q_pop      = 1'b0;
    note_we    = 1'b0;
    drum_we    = 1'b0;
    note_wa    = note_addr(q_item.chan, q_item.eidx);
    drum_wa    = q_item.eidx[TBL_AW-1:0];
    note_re    = 1'b0;
    drum_re    = 1'b0;
    note_ra    = note_addr(ch_r, pos_fix);
    drum_ra    = dpos_fix[TBL_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          ch_nxt = CH_MELODY;
          unique case (q_item.op)
            CMD_TICK: begin
              if (play_r) begin
                for (int i = 0; i < 3; i++) begin
                  if (yld_r[i] != 8'd0) begin
                    yld_nxt[i] = 8'(yld_r[i] - 8'd1);
                  end
                end
                state_nxt = S_ADDR;
              end
            end
            CMD_START: begin
              for (int i = 0; i < 3; i++) begin
                pos_nxt[i] = 8'd0;
                tmr_nxt[i] = 8'd0;
                lst_nxt[i] = 8'd0;
                yld_nxt[i] = 8'd0;
              end
              rtg_nxt  = 3'b111;
              dpos_nxt = 8'd0;
              dtmr_nxt = 8'd0;
              play_nxt = 1'b1;
            end
            CMD_PAUSE: begin
              play_nxt  = 1'b0;
              state_nxt = S_PSIL;
            end
            CMD_RESUME: begin
              if (!play_r) begin
                play_nxt = 1'b1;
                rtg_nxt  = 3'b111;
              end
            end
            CMD_CLAIM: begin
              if (q_item.chan == CH_MELODY || q_item.chan == CH_HARMONY) begin
                yld_nxt[q_item.chan] = q_item.frames;
                rtg_nxt[q_item.chan] = 1'b1;
              end else if (q_item.chan == CH_DRUM) begin
                yld_nxt[2] = q_item.frames;
              end
            end
            CMD_LOAD: begin
              note_we = (q_item.chan != CH_DRUM);
              drum_we = (q_item.chan == CH_DRUM);
            end
            default: ;
          endcase
        end
      end

      S_ADDR: begin
        if (ch_r == CH_DRUM) begin
          if (dtdec == 8'd0) begin
            drum_re   = 1'b1;
            dpos_nxt  = dpos_adv;
            fire_nxt  = 1'b1;
            emit_nxt  = (yld_r[2] == 8'd0);
            state_nxt = S_DATA;
          end else begin
            dtmr_nxt  = dtdec;
            state_nxt = S_FLUSH;
          end
        end else if (len == 9'd0) begin
          // empty channel: nothing moves, pending retrigger stays
          ch_nxt = 2'(ch_r + 2'd1);
        end else if (tdec == 8'd0) begin
          note_re          = 1'b1;
          pos_nxt[ch_r]    = pos_adv;
          lst_nxt[ch_r]    = pos_fix;
          rtg_nxt[ch_r]    = 1'b0;
          fire_nxt         = 1'b1;
          emit_nxt         = !held;
          state_nxt        = S_DATA;
        end else begin
          pos_nxt[ch_r] = pos_fix;
          tmr_nxt[ch_r] = tdec;
          if (rtg_r[ch_r] && !held) begin
            note_re       = 1'b1;
            note_ra       = note_addr(ch_r, lst_r[ch_r]);
            rtg_nxt[ch_r] = 1'b0;
            fire_nxt      = 1'b0;
            emit_nxt      = 1'b1;
            state_nxt     = S_DATA;
          end else begin
            ch_nxt = 2'(ch_r + 2'd1);
          end
        end
      end

      S_DATA: begin
        if (!emit_r || can_prod) begin
          if (fire_r) begin
            if (ch_r == CH_DRUM) begin
              dtmr_nxt = tval;
            end else begin
              tmr_nxt[ch_r] = tval;
            end
          end
          if (emit_r) begin
            push       = hold_v_r;
            hold_nxt   = new_res;
            hold_v_nxt = 1'b1;
          end
          if (ch_r == CH_DRUM) begin
            state_nxt = S_FLUSH;
          end else begin
            ch_nxt    = 2'(ch_r + 2'd1);
            state_nxt = S_ADDR;
          end
        end
      end

      S_PSIL: begin
        if (can_prod) begin
          push       = hold_v_r;
          hold_nxt   = new_res;
          hold_v_nxt = 1'b1;
          if (ch_r == CH_DRUM) begin
            state_nxt = S_FLUSH;
          end else begin
            ch_nxt = 2'(ch_r + 2'd1);
          end
        end
      end

      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_v_nxt = push ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= 8'd0;
        tmr_r[i] <= 8'd0;
        lst_r[i] <= 8'd0;
        yld_r[i] <= 8'd0;
      end
      rtg_r    <= 3'b000;
      dpos_r   <= 8'd0;
      dtmr_r   <= 8'd0;
      play_r   <= 1'b0;
      ch_r     <= CH_MELODY;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_nxt[i];
        tmr_r[i] <= tmr_nxt[i];
        lst_r[i] <= lst_nxt[i];
        yld_r[i] <= yld_nxt[i];
      end
      rtg_r    <= rtg_nxt;
      dpos_r   <= dpos_nxt;
      dtmr_r   <= dtmr_nxt;
      play_r   <= play_nxt;
      ch_r     <= ch_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fire_r <= fire_nxt;
    emit_r <= emit_nxt;
    hold_r <= hold_nxt;
    if (push) begin
      out_r      <= push_res;
      out_last_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch1_len_r  <= 8'd0;
      ch1_loop_r <= 8'd0;
      ch2_len_r  <= 8'd0;
      ch3_len_r  <= 8'd0;
      drum_len_r <= 8'd0;
      rest_r     <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CH1_LEN:  ch1_len_r  <= cfg_wdata[7:0];
        REG_CH1_LOOP: ch1_loop_r <= cfg_wdata[7:0];
        REG_CH2_LEN:  ch2_len_r  <= cfg_wdata[7:0];
        REG_CH3_LEN:  ch3_len_r  <= cfg_wdata[7:0];
        REG_DRUM_LEN: drum_len_r <= cfg_wdata[7:0];
        REG_REST:     rest_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // note table: {duration, pitch}
  always_ff @(posedge clk) begin
    if (note_we) begin
      note_mem[note_wa] <= {q_item.dur, q_item.pitch};
    end
    if (note_re) begin
      note_rd_r <= note_mem[note_ra];
    end
  end

  // drum table: {duration, envelope, noise}
  always_ff @(posedge clk) begin
    if (drum_we) begin
      drum_mem[drum_wa] <= {q_item.dur, q_item.env, q_item.noise};
    end
    if (drum_re) begin
      drum_rd_r <= drum_mem[drum_ra];
    end
  end

  assign out_tvalid  = out_v_r;
  assign out_tdata   = {5'd0, out_r.noise, out_r.env, out_r.pitch};
  assign out_tuser   = {out_r.action, out_r.chan};
  assign out_tlast   = out_last_r;
  assign stat.busy   = (state_r != S_IDLE);
  assign stat.hold_v = hold_v_r;

endmodule

/* hdl/tone_sequencer_with_channel_yield_core.sv */
// Top level of the four-channel tone sequencer with effect yield.
//
//  channel   dir  handshake              payload
//  in_       in   in_tvalid/in_tready    in_tdata, in_tuser (one command)
//  out_      out  out_tvalid/out_tready  out_tdata, out_tuser, out_tlast (one event)
//  cfg_      in   cfg_we                 cfg_addr, cfg_wdata (register write)
//
// Cycles: load, claim, start, resume and a tick while stopped take 1 cycle in the back
//   end. A running tick passes each channel through S_ADDR, and each channel whose timer
//   runs out or that replays a note also through S_DATA, waiting for its registered
//   table read; S_FLUSH then hands over the last event. Pause walks S_PSIL per channel.
// A two-deep command queue lets input transactions land while the back end works.
// Reset (rst_n low, synchronous) clears all sequencer and config state; the event
//   tables are not cleared and hold garbage until loaded.
// A stalled output holds the back end only when it has a further event to hand over.
`timescale 1ns / 1ps
module tone_sequencer_with_channel_yield_core import tsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // commands
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // claim_frames, entry_index, entry_duration,
                                  // entry_pitch, entry_envelope, entry_noise
  input  logic [4:0]  in_tuser,   // cmd[2:0], channel[4:3]
  // channel events
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pitch[10:0], drum_envelope[18:11],
                                  // drum_noise[26:19], zero fill
  output logic [3:0]  out_tuser,  // out_channel[1:0], action[3:2]
  output logic        out_tlast,
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic      q_valid;
  qitem_t    q_item;
  logic      q_pop;
  eng_stat_t eng_stat;

  // front: decode and queue commands
  tsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: run the channels, one event per transaction out
  tsq_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .stat       (eng_stat)
  );

`ifndef ASSERT_OFF
  // drum hits only ever go to the drum channel
  a_drum_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:2] == ACT_DRUM |-> out_tuser[1:0] == CH_DRUM)
    else $error("drum hit on a pitched channel");

  // only note starts carry a pitch
  a_pitch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:2] != ACT_START |-> out_tdata[10:0] == 11'd0)
    else $error("pitch set on a non-start event");

  // back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a held event never outlives its command
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.hold_v |-> eng_stat.busy)
    else $error("held event while back end idle");
`endif

endmodule

/* dv/tone_event_checker.sv */
// Tone sequencer checker: mirrors the sequencer state and compares every output event.
`timescale 1ns / 1ps
module tone_event_checker import tsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [4:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        done,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  chan;
    logic [1:0]  action;
    logic [10:0] pitch;
    logic [7:0]  env;
    logic [7:0]  noise;
    logic        last;
  } tone_event_t;

  tone_event_t expected_events[$];
  tone_event_t burst[4];
  int          burst_n;
  int          fail_count = 0;
  int          queued = 0;

  // event tables
  logic [7:0]  note_dur   [NOTE_DEPTH];
  logic [15:0] note_pitch [NOTE_DEPTH];
  logic [7:0]  drum_dur   [TABLE_DEPTH];
  logic [7:0]  drum_env   [TABLE_DEPTH];
  logic [7:0]  drum_noise [TABLE_DEPTH];

  // sequencer state; hold_frames[2] belongs to the drums
  logic [7:0]  voice_pos   [3];
  logic [7:0]  voice_timer [3];
  logic [7:0]  voice_last  [3];
  logic        voice_rearm [3];
  logic [7:0]  hold_frames [3];
  logic [7:0]  kit_pos;
  logic [7:0]  kit_wait;
  logic        running;

  logic [7:0]  mel_len, mel_loop, har_len, bass_len, drum_len;
  logic [15:0] rest_pitch;

  assign fails   = fail_count;
  assign pending = queued;

  task automatic report(input string msg);
    $display("[%0t] tone check: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic emit(input logic [1:0] ch, input logic [1:0] act, input logic [10:0] p,
                      input logic [7:0] e, input logic [7:0] n);
    burst[burst_n] = '{chan: ch, action: act, pitch: p, env: e, noise: n, last: 1'b0};
    burst_n++;
  endtask

  task automatic clear_state();
    for (int c = 0; c < 3; c++) begin
      voice_pos[c]   = '0;
      voice_timer[c] = '0;
      voice_last[c]  = '0;
      voice_rearm[c] = 1'b0;
      hold_frames[c] = '0;
    end
    kit_pos    = '0;
    kit_wait   = '0;
    running    = 1'b0;
    mel_len    = '0;
    mel_loop   = '0;
    har_len    = '0;
    bass_len   = '0;
    drum_len   = '0;
    rest_pitch = '0;
    expected_events.delete();
  endtask

  // one frame of a pitched voice; fire says a start or silence event goes out
  task automatic advance_voice(input int c, input logic [8:0] len, input logic [8:0] loop_in,
                               input bit held, output bit fire, output logic [7:0] idx);
    logic [8:0] lp;
    logic [8:0] p;
    logic [7:0] d;
    fire = 1'b0;
    idx  = '0;
    lp   = (loop_in >= len) ? 9'd0 : loop_in;
    if (len != 0) begin
      p = {1'b0, voice_pos[c]};
      if (p >= len) p = lp;
      if (voice_timer[c] != 0) voice_timer[c] = voice_timer[c] - 8'd1;
      if (voice_timer[c] == 0) begin
        d = note_dur[c * TABLE_DEPTH + int'(p)];
        voice_timer[c] = (d != 0) ? d : 8'd1;
        voice_last[c]  = p[7:0];
        idx            = p[7:0];
        p              = p + 9'd1;
        if (p >= len) p = lp;
        voice_pos[c]   = p[7:0];
        voice_rearm[c] = 1'b0;
        fire           = !held;
      end else begin
        voice_pos[c] = p[7:0];
        if (voice_rearm[c] && !held) begin
          voice_rearm[c] = 1'b0;
          idx            = voice_last[c];
          fire           = 1'b1;
        end
      end
    end
  endtask

  task automatic predict_command(input logic [2:0] cmd, input logic [1:0] chan,
                                 input logic [7:0] frames, input logic [7:0] eidx,
                                 input logic [7:0] dur, input logic [15:0] pitch,
                                 input logic [7:0] env, input logic [7:0] noise);
    logic [8:0]  lens [3];
    logic [8:0]  loops [3];
    logic [8:0]  dp;
    logic [7:0]  e;
    logic [7:0]  idx;
    logic [15:0] p;
    bit          fire;
    burst_n = 0;
    case (cmd)
      CMD_TICK: begin
        if (running) begin
          for (int c = 0; c < 3; c++)
            if (hold_frames[c] != 0) hold_frames[c] = hold_frames[c] - 8'd1;
          lens[0]  = {1'b0, mel_len};
          lens[1]  = {1'b0, har_len};
          lens[2]  = {1'b0, bass_len};
          loops[0] = {1'b0, mel_loop};
          loops[1] = 9'd0;
          loops[2] = 9'd0;
          for (int c = 0; c < 3; c++) begin
            advance_voice(c, lens[c], loops[c], (c < 2) && (hold_frames[c] != 0), fire, idx);
            if (fire) begin
              p = note_pitch[c * TABLE_DEPTH + int'(idx)];
              if (p == rest_pitch) emit(2'(c), ACT_SILENCE, '0, '0, '0);
              else emit(2'(c), ACT_START, p[10:0], '0, '0);
            end
          end
          if (kit_wait != 0) kit_wait = kit_wait - 8'd1;
          if (kit_wait == 0) begin
            dp = {1'b0, kit_pos};
            if (dp >= {1'b0, drum_len}) dp = 9'd0;
            e        = dp[7:0];
            kit_wait = (drum_dur[e] != 0) ? drum_dur[e] : 8'd1;
            dp       = dp + 9'd1;
            if (dp >= {1'b0, drum_len}) dp = 9'd0;
            kit_pos  = dp[7:0];
            if (hold_frames[2] == 0) emit(CH_DRUM, ACT_DRUM, '0, drum_env[e], drum_noise[e]);
          end
        end
      end
      CMD_START: begin
        for (int c = 0; c < 3; c++) begin
          voice_pos[c]   = '0;
          voice_timer[c] = '0;
          voice_rearm[c] = 1'b1;
          voice_last[c]  = '0;
          hold_frames[c] = '0;
        end
        kit_pos  = '0;
        kit_wait = '0;
        running  = 1'b1;
      end
      CMD_PAUSE: begin
        running = 1'b0;
        for (int c = 0; c < 4; c++) emit(2'(c), ACT_SILENCE, '0, '0, '0);
      end
      CMD_RESUME: begin
        if (!running) begin
          running = 1'b1;
          for (int c = 0; c < 3; c++) voice_rearm[c] = 1'b1;
        end
      end
      CMD_CLAIM: begin
        if (chan == CH_MELODY || chan == CH_HARMONY) begin
          hold_frames[chan] = frames;
          voice_rearm[chan] = 1'b1;
        end else if (chan == CH_DRUM) begin
          hold_frames[2] = frames;
        end
      end
      CMD_LOAD: begin
        if (chan == CH_DRUM) begin
          drum_dur[eidx]   = dur;
          drum_env[eidx]   = env;
          drum_noise[eidx] = noise;
        end else begin
          note_dur[int'(chan) * TABLE_DEPTH + int'(eidx)]   = dur;
          note_pitch[int'(chan) * TABLE_DEPTH + int'(eidx)] = pitch;
        end
      end
      default: ;
    endcase
    if (burst_n > 0) burst[burst_n - 1].last = 1'b1;
    for (int k = 0; k < burst_n; k++) expected_events.push_back(burst[k]);
  endtask

  always @(posedge clk) begin
    tone_event_t want;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CH1_LEN:  mel_len    = cfg_wdata[7:0];
          REG_CH1_LOOP: mel_loop   = cfg_wdata[7:0];
          REG_CH2_LEN:  har_len    = cfg_wdata[7:0];
          REG_CH3_LEN:  bass_len   = cfg_wdata[7:0];
          REG_DRUM_LEN: drum_len   = cfg_wdata[7:0];
          REG_REST:     rest_pitch = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected event: channel %0d action %0d",
                           out_tuser[1:0], out_tuser[3:2]));
        end else begin
          want = expected_events.pop_front();
          check_field("channel", out_tuser[1:0], want.chan);
          check_field("action", out_tuser[3:2], want.action);
          check_field("pitch", out_tdata[10:0], want.pitch);
          check_field("drum envelope", out_tdata[18:11], want.env);
          check_field("drum noise", out_tdata[26:19], want.noise);
          check_field("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready)
        predict_command(in_tuser[2:0], in_tuser[4:3], in_tdata[7:0], in_tdata[15:8],
                        in_tdata[23:16], in_tdata[39:24], in_tdata[47:40], in_tdata[55:48]);
    end
    queued = expected_events.size();
  end

  always @(posedge done) begin
    if (expected_events.size() != 0)
      report($sformatf("%0d expected events never arrived", expected_events.size()));
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the tone sequencer: stimulus, reset, register setup and verdict.
`timescale 1ns / 1ps
module tb_top;
  import tsq_pkg::*;

  // codes the block has no use for; they must pass without effect
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // table entries loaded up front; no phase sets a length above this
  localparam int PRELOAD = 16;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [55:0] in_tdata   = '0;   // claim_frames, entry_index, entry_duration,
                                  // entry_pitch, entry_envelope, entry_noise
  logic [4:0]  in_tuser   = '0;   // cmd, channel
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = REG_CH1_LEN;
  logic [15:0] cfg_wdata  = '0;
  logic        done       = 1'b0;

  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;         // pitch, drum_envelope, drum_noise, zero fill
  logic [3:0]  out_tuser;         // out_channel, action
  logic        out_tlast;

  int          fails;
  int          pending;

  // idle percentages of the two sides, changed per phase
  int          send_gap_pct = 25;
  int          recv_gap_pct = 61;

  // in_tready as it stands just before the next rising edge
  logic        in_ready_seen = 1'b0;

  always #2 clk = ~clk;

  always @(negedge clk) in_ready_seen <= in_tready;

  // receiver stalls at random, one decision per cycle
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_gap_pct);

  tone_sequencer_with_channel_yield_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tone_event_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .fails      (fails),
    .pending    (pending)
  );

  // One command transaction. Random idle cycles go first; valid then stays up until
  // the edge where ready is high. Returns on that edge, valid still high.
  task automatic put(input logic [2:0] cmd, input logic [1:0] chan, input logic [7:0] frames,
                     input logic [7:0] eidx, input logic [7:0] dur, input logic [15:0] pitch,
                     input logic [7:0] env, input logic [7:0] noise);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {chan, cmd};
    in_tdata  <= {noise, env, pitch, dur, eidx, frames};
    @(posedge clk);
    while (!in_ready_seen) @(posedge clk);
  endtask

  // non-load commands carry junk in the entry fields, which the block must ignore
  task automatic put_cmd(input logic [2:0] cmd, input logic [1:0] chan, input logic [7:0] frames);
    put(cmd, chan, frames, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
        8'($urandom));
  endtask

  // mostly short notes so that ticks keep starting events
  function automatic logic [7:0] pick_dur();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'd0;
    if (r < 75) return 8'($urandom_range(3, 1));
    if (r < 95) return 8'($urandom_range(8, 4));
    return 8'($urandom);
  endfunction

  // a good share of pitches collide with the rest codes used below
  function automatic logic [15:0] pick_pitch();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h1234;
      default: return 16'($urandom);
    endcase
  endfunction

  // claims are mostly short so they run out within a phase
  function automatic logic [7:0] pick_frames();
    if ($urandom_range(9) < 7) return 8'($urandom_range(6));
    return 8'($urandom);
  endfunction

  task automatic put_load(input logic [1:0] chan, input logic [7:0] eidx);
    put(CMD_LOAD, chan, 8'($urandom), eidx, pick_dur(), pick_pitch(), 8'($urandom),
        8'($urandom));
  endtask

  // Sender holds off until every expected event is out, then lets the back end
  // settle: a tick may still be running and two more commands may sit in the queue.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic poke(input logic [2:0] addr, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // all six registers back to back; only called while the block is idle
  task automatic write_regs(input logic [15:0] ch1, input logic [15:0] loop1,
                            input logic [15:0] ch2, input logic [15:0] ch3,
                            input logic [15:0] drums, input logic [15:0] rest);
    poke(REG_CH1_LEN, ch1);
    poke(REG_CH1_LOOP, loop1);
    poke(REG_CH2_LEN, ch2);
    poke(REG_CH3_LEN, ch3);
    poke(REG_DRUM_LEN, drums);
    poke(REG_REST, rest);
    cfg_we <= 1'b0;
  endtask

  // Weighted mix: ticks dominate so the voices walk their tables, with loads,
  // claims, pause/resume and restarts stirred in, plus a few spare codes.
  task automatic random_phase(input int n_items);
    int r;
    put_cmd(CMD_RESUME, CH_MELODY, 8'd0);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 46)      put_cmd(CMD_TICK, 2'($urandom), 8'($urandom));
      else if (r < 60) put_load(2'($urandom), 8'($urandom));
      else if (r < 73) put_cmd(CMD_CLAIM, 2'($urandom), pick_frames());
      else if (r < 78) put_cmd(CMD_START, 2'($urandom), 8'($urandom));
      else if (r < 83) put_cmd(CMD_PAUSE, 2'($urandom), 8'($urandom));
      else if (r < 96) put_cmd(CMD_RESUME, 2'($urandom), 8'($urandom));
      else if (r < 98) put_cmd(CMD_SPARE_LO, 2'($urandom), 8'($urandom));
      else             put_cmd(CMD_SPARE_HI, 2'($urandom), 8'($urandom));
      // occasional full drain in the middle of a phase
      if ($urandom_range(59) == 0) wait_quiet();
    end
    wait_quiet();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The first PRELOAD entries of every table get written once; no length set
    // below goes past them, so no tick can read an entry that was never loaded.
    for (int ch = 0; ch < 4; ch++)
      for (int i = 0; i < PRELOAD; i++)
        put_load(2'(ch), 8'(i));

    // Directed part, registers still at reset: all voices have zero length,
    // the drum table length is zero so drum entry 0 repeats.
    put_cmd(CMD_TICK, CH_MELODY, 8'd0);     // stopped: tick does nothing
    put_cmd(CMD_PAUSE, CH_MELODY, 8'd0);    // pause while paused still silences all four
    put_cmd(CMD_CLAIM, CH_MELODY, 8'd3);    // claim lands while stopped
    put_cmd(CMD_CLAIM, CH_BASS, 8'hFF);     // bass claims are dropped
    put_cmd(CMD_RESUME, CH_MELODY, 8'd0);   // plays and arms every retrigger
    put_cmd(CMD_TICK, CH_MELODY, 8'd0);     // zero-length voices skipped, retriggers stay armed
    put_cmd(CMD_CLAIM, CH_DRUM, 8'hFF);     // longest drum claim mutes hits
    put_cmd(CMD_TICK, CH_DRUM, 8'd0);
    put_cmd(CMD_TICK, CH_DRUM, 8'd0);
    put_cmd(CMD_SPARE_LO, CH_DRUM, 8'd0);
    put_cmd(CMD_SPARE_HI, CH_DRUM, 8'd0);
    // entry extremes: index 255, all-ones bytes, zero durations
    put(CMD_LOAD, CH_DRUM, 8'd0, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
    put(CMD_LOAD, CH_MELODY, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 8'h00, 8'h00);
    put(CMD_LOAD, CH_HARMONY, 8'h00, 8'h00, 8'hFF, 16'h0000, 8'h00, 8'h00);
    put(CMD_LOAD, CH_DRUM, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00);
    put_cmd(CMD_START, CH_BASS, 8'd0);      // clears the drum claim
    put_cmd(CMD_RESUME, CH_BASS, 8'd0);     // already playing: no effect
    put_cmd(CMD_TICK, CH_BASS, 8'd0);
    put_cmd(CMD_TICK, CH_BASS, 8'd0);
    put_cmd(CMD_CLAIM, CH_HARMONY, 8'd0);   // zero-frame claim only rearms
    put_cmd(CMD_TICK, CH_BASS, 8'd0);
    put_cmd(CMD_PAUSE, CH_BASS, 8'd0);
    wait_quiet();

    // sender idles a quarter of the time, receiver most of it
    write_regs(16'd6, 16'd2, 16'd3, 16'd1, 16'd5, 16'h1234);
    random_phase(32);

    // sides swapped; longest lengths in use, loop start on the last melody entry
    // and all-ones rest code
    send_gap_pct = 61;
    recv_gap_pct = 25;
    write_regs(16'(PRELOAD), 16'(PRELOAD - 1), 16'(PRELOAD), 16'(PRELOAD), 16'(PRELOAD),
               16'hFFFF);
    random_phase(32);
    // short tables now: positions left past the end fold back, loop start
    // beyond the melody length falls back to 0, harmony goes silent
    write_regs(16'd3, 16'd200, 16'd0, 16'd2, 16'd1, 16'h0000);
    random_phase(32);

    // no idling from here on
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_regs(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'h0000);
    random_phase(32);
    write_regs(16'($urandom_range(12)), 16'($urandom_range(15)), 16'($urandom_range(12)),
               16'($urandom_range(12)), 16'($urandom_range(12)), pick_pitch());
    random_phase(32);

    done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* tone_sequencer_with_channel_yield_core.f */
hdl/tsq_pkg.sv
hdl/tsq_front.sv
hdl/tsq_engine.sv
hdl/tone_sequencer_with_channel_yield_core.sv
dv/tone_event_checker.sv
dv/tb_top.sv
